// ===== hw/rtl/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; imported by every wsd module.
`default_nettype none

package wsd_pkg;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // parser phases
  localparam logic [2:0] PH_HDR0  = 3'd0;
  localparam logic [2:0] PH_HDR1  = 3'd1;
  localparam logic [2:0] PH_EXT16 = 3'd2;
  localparam logic [2:0] PH_EXT64 = 3'd3;
  localparam logic [2:0] PH_MASK  = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_ERROR = 3'd6;

  localparam logic [7:0]  FIN_BIT      = 8'h80;
  localparam logic [7:0]  OPCODE_MASK  = 8'h0F;
  localparam logic [7:0]  LEN7_MASK    = 8'h7F;
  localparam logic [6:0]  LEN7_EXT16   = 7'd126;
  localparam logic [6:0]  LEN7_EXT64   = 7'd127;
  localparam logic [31:0] MAX_LEN_RST  = 32'd67108864;  // 64 MiB

  // one classified beat handed from the front to the back
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  key;
    logic [3:0]  opcode;
    logic        fin;
    logic        masked;
    logic [31:0] length;
    logic        last;
  } item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wsd_front.sv =====
// Header parser: walks the frame header, checks the length and tags each beat.
// Depends on wsd_pkg.
`default_nettype none

module wsd_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [7:0]          in_stream_byte,
  input  wire  [31:0]         max_len,
  input  wire                 q_full,
  output logic                push,
  output wsd_pkg::item_t      push_item
);
  import wsd_pkg::*;

  logic [2:0]  phase_r,  phase_nxt;
  logic [2:0]  cnt_r,    cnt_nxt;
  logic        fin_r,    fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic [63:0] len_r,    len_nxt;
  logic [31:0] key_r,    key_nxt;
  logic [1:0]  idx_r,    idx_nxt;
  logic [31:0] rem_r,    rem_nxt;

  logic        fire;
  logic        len_over;
  logic [6:0]  len7;
  logic        check_len;
  logic        start_pay;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign len7     = 7'(in_stream_byte & LEN7_MASK);
  assign len_over = (|len_nxt[63:32]) || (len_nxt[31:0] > max_len);

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    rem_nxt    = rem_r;
    check_len  = 1'b0;
    start_pay  = 1'b0;
    push       = 1'b0;

    push_item.kind   = KIND_DATA;
    push_item.data   = 8'd0;
    push_item.key    = 8'd0;
    push_item.opcode = opcode_r;
    push_item.fin    = fin_r;
    push_item.masked = masked_r;
    push_item.length = 32'd0;
    push_item.last   = 1'b1;

    if (fire) begin
      unique case (phase_r)
        PH_HDR0: begin
          fin_nxt    = |(in_stream_byte & FIN_BIT);
          opcode_nxt = 4'(in_stream_byte & OPCODE_MASK);
          key_nxt    = 32'd0;
          len_nxt    = 64'd0;
          phase_nxt  = PH_HDR1;
        end
        PH_HDR1: begin
          masked_nxt = |(in_stream_byte & FIN_BIT);
          cnt_nxt    = 3'd0;
          len_nxt    = 64'd0;
          if (len7 == LEN7_EXT16) begin
            phase_nxt = PH_EXT16;
          end else if (len7 == LEN7_EXT64) begin
            phase_nxt = PH_EXT64;
          end else begin
            len_nxt   = 64'(len7);
            check_len = 1'b1;
          end
        end
        PH_EXT16, PH_EXT64: begin
          len_nxt = {len_r[55:0], in_stream_byte};
          if (cnt_r >= ((phase_r == PH_EXT16) ? 3'd1 : 3'd7)) begin
            check_len = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], in_stream_byte};
          if (cnt_r >= 3'd3) begin
            start_pay = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        PH_DATA: begin
          push           = 1'b1;
          push_item.kind = KIND_DATA;
          push_item.data = in_stream_byte;
          push_item.key  = key_r[8 * (2'd3 - idx_r) +: 8];
          push_item.last = (rem_r == 32'd1);
          if (rem_r == 32'd1) begin
            phase_nxt = PH_HDR0;
          end else begin
            idx_nxt = idx_r + 2'd1;
            rem_nxt = rem_r - 32'd1;
          end
        end
        default: begin
          // error phase and unused codes swallow input
        end
      endcase

      if (check_len) begin
        if (len_over) begin
          push           = 1'b1;
          push_item.kind = KIND_ERROR;
          phase_nxt      = PH_ERROR;
        end else if (masked_nxt) begin
          cnt_nxt   = 3'd0;
          phase_nxt = PH_MASK;
        end else begin
          start_pay = 1'b1;
        end
      end

      if (start_pay) begin
        if (len_nxt == 64'd0) begin
          push           = 1'b1;
          push_item.kind = KIND_EMPTY;
          phase_nxt      = PH_HDR0;
        end else begin
          idx_nxt   = 2'd0;
          rem_nxt   = len_nxt[31:0];
          phase_nxt = PH_DATA;
        end
      end
    end

    push_item.fin    = fin_nxt;
    push_item.masked = masked_nxt;
    push_item.opcode = opcode_nxt;
    push_item.length = (|len_nxt[63:32]) ? 32'hFFFF_FFFF : len_nxt[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      cnt_r    <= 3'd0;
      fin_r    <= 1'b0;
      opcode_r <= 4'd0;
      masked_r <= 1'b0;
      len_r    <= 64'd0;
      key_r    <= 32'd0;
      idx_r    <= 2'd0;
      rem_r    <= 32'd0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      fin_r    <= fin_nxt;
      opcode_r <= opcode_nxt;
      masked_r <= masked_nxt;
      len_r    <= len_nxt;
      key_r    <= key_nxt;
      idx_r    <= idx_nxt;
      rem_r    <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wsd_queue.sv =====
// Small FIFO of classified beats between the parser and the output stage.
// Depends on wsd_pkg.
`default_nettype none

module wsd_queue #(
  parameter int DEPTH = 4
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  wsd_pkg::item_t      push_item,
  output logic                full,
  input  wire                 pop,
  output logic                avail,
  output wsd_pkg::item_t      head
);
  import wsd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r,  count_nxt;
  logic               do_pop;

  assign full   = (count_r == CNT_W'(DEPTH));
  assign avail  = (count_r != '0);
  assign head   = mem[rd_ptr_r];
  assign do_pop = pop && avail;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wsd_back.sv =====
// Output stage: unmasks payload beats and holds the result register.
// Depends on wsd_pkg.
`default_nettype none

module wsd_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 avail,
  input  wsd_pkg::item_t      head,
  output logic                pop,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_payload_byte,
  output logic [3:0]          out_opcode,
  output logic                out_fin,
  output logic                out_masked,
  output logic [31:0]         out_payload_length,
  output logic                out_last_in_frame
);
  import wsd_pkg::*;

  logic        valid_r;
  logic [1:0]  kind_r;
  logic [7:0]  byte_r;
  logic [3:0]  opcode_r;
  logic        fin_r;
  logic        masked_r;
  logic [31:0] length_r;
  logic        last_r;

  // refill whenever the register is empty or being drained this cycle
  assign pop = avail && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r   <= head.kind;
      byte_r   <= (head.kind == KIND_DATA) ? (head.data ^ head.key) : 8'd0;
      opcode_r <= head.opcode;
      fin_r    <= head.fin;
      masked_r <= head.masked;
      length_r <= head.length;
      last_r   <= head.last;
    end
  end

  assign out_valid          = valid_r;
  assign out_kind           = kind_r;
  assign out_payload_byte   = byte_r;
  assign out_opcode         = opcode_r;
  assign out_fin            = fin_r;
  assign out_masked         = masked_r;
  assign out_payload_length = length_r;
  assign out_last_in_frame  = last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/websocket_frame_deframer.sv =====
// WebSocket frame deframer top level.
// Channels: in_* carries one stream byte per beat (valid/ready); out_* carries
// one result per beat: a payload byte (unmasked), an empty-frame marker or a
// length error, with the frame's opcode, FIN, MASK and length alongside.
// cfg_* writes max_payload_len; cfg_ready is always high. Write it only while
// the block is idle; a new value is used at the next length check.
// Throughput: one byte per clock unless the queue is full. Header and mask-key
// bytes give no result but an empty-frame marker or length error at their end.
// A result is queued on the edge that takes its byte, then moved to out_*.
// Reset (synchronous, rst_n low): parser back to the first header byte,
// queue emptied, max_payload_len back to 64 MiB. After a length error all
// input is taken and dropped until reset.
// Stalls: while out_ready is low the output register holds its beat and the
// queue (QUEUE_DEPTH entries) keeps filling; in_ready drops only when it is
// full, so short receiver stalls do not back up the byte stream.
// Depends on wsd_pkg, wsd_front, wsd_queue, wsd_back.
`default_nettype none

module websocket_frame_deframer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_stream_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [3:0]  out_opcode,
  output logic        out_fin,
  output logic        out_masked,
  output logic [31:0] out_payload_length,
  output logic        out_last_in_frame,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [31:0] cfg_max_payload_len
);
  import wsd_pkg::*;

  logic [31:0] max_len_r;
  logic        q_full;
  logic        q_push;
  item_t       q_push_item;
  logic        q_pop;
  logic        q_avail;
  item_t       q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_max_payload_len;
    end
  end

  wsd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_stream_byte (in_stream_byte),
    .max_len        (max_len_r),
    .q_full         (q_full),
    .push           (q_push),
    .push_item      (q_push_item)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  wsd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .avail              (q_avail),
    .head               (q_head),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_opcode         (out_opcode),
    .out_fin            (out_fin),
    .out_masked         (out_masked),
    .out_payload_length (out_payload_length),
    .out_last_in_frame  (out_last_in_frame)
  );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Testbench for websocket_frame_deframer: directed rows, random frames, more rows.
// Expected results: local frame parser model or typed rows. Depends on wsd_pkg.

module tb;
  import wsd_pkg::*;

  localparam int N_OPEN         = 27;  // rows played before the random part
  localparam int N_ROWS         = 40;  // the rest end the run with a length error
  localparam int BYTES_PER_STEP = 170;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  pbyte;
    logic [3:0]  opcode;
    logic        fin;
    logic        masked;
    logic [31:0] length;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;  // want holds the hand-written result
    res_t       want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_stream_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_payload_byte;
  logic [3:0]  out_opcode;
  logic        out_fin;
  logic        out_masked;
  logic [31:0] out_payload_length;
  logic        out_last_in_frame;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_max_payload_len = 32'd0;

  websocket_frame_deframer uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_stream_byte     (in_stream_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_payload_byte   (out_payload_byte),
    .out_opcode         (out_opcode),
    .out_fin            (out_fin),
    .out_masked         (out_masked),
    .out_payload_length (out_payload_length),
    .out_last_in_frame  (out_last_in_frame),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_payload_len(cfg_max_payload_len)
  );

  always #5 clk = ~clk;

  row_t dir_tab [N_ROWS] = '{
    // empty ping frame, reset limit
    '{8'h89, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_EMPTY, 8'h00, 4'h9, 1'b1, 1'b0, 32'd0, 1'b1}},
    // fin clear, RSV set, 16-bit length of 1
    '{8'h70, 1'b0, '0}, '{8'h7E, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b1, '{KIND_DATA, 8'hFF, 4'h0, 1'b0, 1'b0, 32'd1, 1'b1}},
    // masked, 64-bit length of 2
    '{8'h8F, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h02, 1'b0, '0},
    '{8'hA5, 1'b0, '0}, '{8'h5A, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    // empty frame through the 16-bit form
    '{8'h80, 1'b0, '0}, '{8'h7E, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_EMPTY, 8'h00, 4'h0, 1'b1, 1'b0, 32'd0, 1'b1}},
    // 2^32 bytes against an all-ones limit: error, length saturated
    '{8'h88, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h01, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_ERROR, 8'h00, 4'h8, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1}},
    // dropped after the error
    '{8'h81, 1'b0, '0}, '{8'h01, 1'b0, '0}, '{8'h41, 1'b0, '0}
  };

  row_t        byte_backlog [$];
  res_t        pending_results [$];
  int unsigned n_bytes, n_random_bytes, n_results, n_limits, n_fail, quiet;

  // parser model state
  logic [2:0]  p_phase;
  logic [2:0]  p_cnt;
  logic        p_fin;
  logic [3:0]  p_opc;
  logic        p_mask;
  logic [63:0] p_len;
  logic [31:0] p_key;
  logic [31:0] p_idx;
  logic [31:0] p_limit;

  function automatic res_t frame_result(logic [1:0] k, logic [7:0] d, logic last);
    res_t r;
    r.kind   = k;
    r.pbyte  = d;
    r.opcode = p_opc;
    r.fin    = p_fin;
    r.masked = p_mask;
    r.length = (p_len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p_len[31:0];
    r.last   = last;
    return r;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
    bit         has = 1'b0;
    bit         len_done = 1'b0;
    bit         pay_start = 1'b0;
    logic [7:0] key_b;
    r = '0;
    case (p_phase)
      PH_HDR0: begin
        p_fin   = (b & FIN_BIT) != 8'h00;
        p_opc   = 4'(b & OPCODE_MASK);
        p_key   = '0;
        p_len   = '0;
        p_phase = PH_HDR1;
      end
      PH_HDR1: begin
        p_mask = b[7];
        p_len  = '0;
        p_cnt  = '0;
        if (7'(b & LEN7_MASK) == LEN7_EXT16) p_phase = PH_EXT16;
        else if (7'(b & LEN7_MASK) == LEN7_EXT64) p_phase = PH_EXT64;
        else begin
          p_len    = 64'(b & LEN7_MASK);
          len_done = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        p_len = {p_len[55:0], b};
        if (p_cnt >= ((p_phase == PH_EXT16) ? 3'd1 : 3'd7)) len_done = 1'b1;
        else p_cnt++;
      end
      PH_MASK: begin
        p_key = {p_key[23:0], b};
        if (p_cnt >= 3'd3) pay_start = 1'b1;
        else p_cnt++;
      end
      PH_DATA: begin
        // first key byte sits in the high bits
        key_b = p_key[8 * (3 - p_idx[1:0]) +: 8];
        r     = frame_result(KIND_DATA, b ^ key_b, ({32'd0, p_idx} + 64'd1 >= p_len));
        has   = 1'b1;
        if (r.last) p_phase = PH_HDR0;
        else p_idx++;
      end
      default: ;
    endcase
    // limit is checked before any mask key byte
    if (len_done) begin
      if (p_len > {32'd0, p_limit}) begin
        r       = frame_result(KIND_ERROR, 8'h00, 1'b1);
        has     = 1'b1;
        p_phase = PH_ERROR;
      end else if (p_mask) begin
        p_cnt   = '0;
        p_phase = PH_MASK;
      end else pay_start = 1'b1;
    end
    if (pay_start) begin
      if (p_len == 64'd0) begin
        r       = frame_result(KIND_EMPTY, 8'h00, 1'b1);
        has     = 1'b1;
        p_phase = PH_HDR0;
      end else begin
        p_idx   = '0;
        p_phase = PH_DATA;
      end
    end
    return has;
  endfunction

  task automatic compare_result(input res_t want, input res_t got);
    bit bad = 1'b0;
    if (got.kind !== want.kind) begin
      bad = 1'b1;
      $display("%0t: kind expected %0d, got %0d", $time, want.kind, got.kind);
    end
    if (got.pbyte !== want.pbyte) begin
      bad = 1'b1;
      $display("%0t: payload_byte expected %h, got %h", $time, want.pbyte, got.pbyte);
    end
    if (got.opcode !== want.opcode) begin
      bad = 1'b1;
      $display("%0t: opcode expected %h, got %h", $time, want.opcode, got.opcode);
    end
    if (got.fin !== want.fin) begin
      bad = 1'b1;
      $display("%0t: fin expected %b, got %b", $time, want.fin, got.fin);
    end
    if (got.masked !== want.masked) begin
      bad = 1'b1;
      $display("%0t: masked expected %b, got %b", $time, want.masked, got.masked);
    end
    if (got.length !== want.length) begin
      bad = 1'b1;
      $display("%0t: payload_length expected %h, got %h", $time, want.length, got.length);
    end
    if (got.last !== want.last) begin
      bad = 1'b1;
      $display("%0t: last_in_frame expected %b, got %b", $time, want.last, got.last);
    end
    if (bad) n_fail++;
  endtask

  // sender: bursts of random length with random gaps
  int unsigned burst_left = 1, gap_left = 0;
  logic        cur_typed = 1'b0;
  res_t        cur_want = '0;

  always @(posedge clk) begin : sender
    res_t r;
    bit   has;
    row_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      p_phase = PH_HDR0;
      p_cnt   = '0;
      p_fin   = 1'b0;
      p_opc   = '0;
      p_mask  = 1'b0;
      p_len   = '0;
      p_key   = '0;
      p_idx   = '0;
      p_limit = MAX_LEN_RST;
    end else begin
      if (in_valid && in_ready) begin
        n_bytes++;
        has = deframe_byte(in_stream_byte, r);
        if (cur_typed) pending_results.insert(pending_results.size(), cur_want);
        else if (has) pending_results.insert(pending_results.size(), r);
      end
      if (!in_valid || in_ready) begin
        if (byte_backlog.size() != 0 && gap_left == 0) begin
          nxt = byte_backlog.pop_front();
          in_valid       <= 1'b1;
          in_stream_byte <= nxt.b;
          cur_typed = nxt.typed;
          cur_want  = nxt.want;
          if (burst_left > 1) burst_left--;
          else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 16);
            gap_left   = $urandom_range(0, 6);
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end
      end
    end
  end

  // receiver: spans of always-ready, coin-flip and mostly-stalled
  int unsigned rx_span = 0, rx_mode = 0;

  always @(posedge clk) begin : receiver
    if (rx_span == 0) begin
      rx_span = $urandom_range(20, 150);
      rx_mode = $urandom_range(0, 2);
    end else rx_span--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin : result_mon
    res_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_kind, out_payload_byte, out_opcode, out_fin, out_masked,
              out_payload_length, out_last_in_frame};
      n_results++;
      if (pending_results.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected result, expected none, got kind %0d byte %h",
                 $time, got.kind, got.pbyte);
      end else compare_result(pending_results.pop_front(), got);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no beat for %0d cycles, %0d results pending",
               $time, quiet, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    byte_backlog.insert(byte_backlog.size(), '{b, 1'b0, '0});
    n_random_bytes++;
  endtask

  // one well-formed frame, length kept within lim
  task automatic queue_frame(input logic [31:0] lim);
    int unsigned len, sel, form;
    logic        msk;
    sel = $urandom_range(0, 99);
    if (sel < 10) len = 0;
    else if (sel < 80) len = $urandom_range(1, 12);
    else if (sel < 96) len = $urandom_range(13, 125);
    else len = $urandom_range(126, 300);
    if (len > lim) len = lim;
    msk  = $urandom_range(0, 1);
    // short lengths also go out in the extended forms (non-minimal)
    if (len > 125) form = $urandom_range(1, 2);
    else form = ($urandom_range(0, 5) < 4) ? 0 : $urandom_range(1, 2);
    queue_byte(8'($urandom_range(0, 255)));
    case (form)
      0: queue_byte({msk, 7'(len)});
      1: begin
        queue_byte({msk, LEN7_EXT16});
        queue_byte(8'(len >> 8));
        queue_byte(8'(len));
      end
      default: begin
        queue_byte({msk, LEN7_EXT64});
        repeat (4) queue_byte(8'h00);
        queue_byte(8'(len >> 24));
        queue_byte(8'(len >> 16));
        queue_byte(8'(len >> 8));
        queue_byte(8'(len));
      end
    endcase
    if (msk) repeat (4) queue_byte(8'($urandom_range(0, 255)));
    repeat (len) queue_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_idle(input int extra);
    while (byte_backlog.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    wait_idle(4);
    cfg_valid           <= 1'b1;
    cfg_max_payload_len <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    p_limit = v;
    n_limits++;
  endtask

  initial begin
    logic [31:0] limits [6];
    int unsigned target;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_OPEN; i++) byte_backlog.insert(byte_backlog.size(), dir_tab[i]);

    limits = '{32'd0, 32'd5, 32'($urandom_range(1, 40)), $urandom(), MAX_LEN_RST,
               32'hFFFF_FFFF};
    foreach (limits[k]) begin
      // sender holds off until all results of the previous step are in
      write_limit(limits[k]);
      target = n_random_bytes + BYTES_PER_STEP;
      while (n_random_bytes < target) queue_frame(limits[k]);
    end

    wait_idle(4);
    for (int i = N_OPEN; i < N_ROWS; i++) byte_backlog.insert(byte_backlog.size(), dir_tab[i]);
    wait_idle(10);

    $display("Sent %0d stream bytes (%0d random) under %0d limit settings; %0d results.",
             n_bytes, n_random_bytes, n_limits, n_results);
    $display("Covered all length forms, masking, empty frames, limit edges and the error lockout.");
    if (n_fail == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
